>>> hdl/sha1md_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants for the SHA-1 digest engine: round constants,
// initial chain value, controller command and status bundles.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int ROUNDS      = 80;
    localparam int RND_CNT_W   = 7;
    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int FILL_W      = 6;
    localparam int BYTE_CNT_W  = 61;

    localparam logic [RND_CNT_W-1:0] LAST_ROUND    = RND_CNT_W'(ROUNDS - 1);
    localparam logic [RND_CNT_W-1:0] STAGE1_START  = RND_CNT_W'(20);
    localparam logic [RND_CNT_W-1:0] STAGE2_START  = RND_CNT_W'(40);
    localparam logic [RND_CNT_W-1:0] STAGE3_START  = RND_CNT_W'(60);
    localparam logic [2:0]           LAST_WORD_IDX = 3'(DIGEST_WORDS - 1);

    localparam logic [FILL_W-1:0] FILL_FULL    = FILL_W'(63);
    localparam logic [FILL_W-1:0] FILL_LEN_POS = FILL_W'(56);

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // source of the byte written into the block buffer
    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic       put;          // write one byte at the fill position
        byte_sel_t  byte_sel;
        logic       count_len;    // byte belongs to the message
        logic       load_rounds;  // copy chain value into a..e
        logic       round;        // run one compression round
        logic [1:0] stage;
        logic       fold;         // add a..e into the chain value
        logic       emit;         // load one digest word into the output register
        logic [2:0] word_idx;
        logic       clear;        // back to the initial state
    } cmd_t;

    typedef struct packed {
        logic fill_last;   // next byte completes the block
        logic fill_is_56;  // length field starts here
        logic out_free;    // output register can take a word
    } sts_t;

endpackage
`default_nettype wire

>>> hdl/sha1md_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer: absorbs items, runs 80 rounds per block, drives byte-wise
// padding and length insertion, then emits the digest words.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             byte_present,
    input  wire logic             end_of_message,
    output logic                  in_stall,
    input  wire sha1md_pkg::sts_t sts,
    output sha1md_pkg::cmd_t      cmd
);
    import sha1md_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [RND_CNT_W-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.put       = 1'b1;
                        cmd.byte_sel  = SEL_MSG;
                        cmd.count_len = 1'b1;
                    end
                    if (byte_present && sts.fill_last)
                    begin
                        cmd.load_rounds = 1'b1;
                        cnt_next        = '0;
                        state_next      = S_ROUND;
                        ret_next        = end_of_message ? S_PAD80 : S_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (cnt_reg < STAGE1_START)
                    cmd.stage = 2'd0;
                else if (cnt_reg < STAGE2_START)
                    cmd.stage = 2'd1;
                else if (cnt_reg < STAGE3_START)
                    cmd.stage = 2'd2;
                else
                    cmd.stage = 2'd3;
                if (cnt_reg == LAST_ROUND)
                    state_next = S_FOLD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                cnt_next   = '0;
                state_next = ret_reg;
            end
            S_PAD80:
            begin
                cmd.put      = 1'b1;
                cmd.byte_sel = SEL_PAD;
                if (sts.fill_last)
                begin
                    cmd.load_rounds = 1'b1;
                    cnt_next        = '0;
                    ret_next        = S_PADZ;
                    state_next      = S_ROUND;
                end
                else
                begin
                    state_next = S_PADZ;
                end
            end
            S_PADZ:
            begin
                if (sts.fill_is_56)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.put      = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    if (sts.fill_last)
                    begin
                        cmd.load_rounds = 1'b1;
                        cnt_next        = '0;
                        ret_next        = S_PADZ;
                        state_next      = S_ROUND;
                    end
                end
            end
            S_LEN:
            begin
                cmd.put      = 1'b1;
                cmd.byte_sel = SEL_LEN;
                if (sts.fill_last)
                begin
                    cmd.load_rounds = 1'b1;
                    cnt_next        = '0;
                    ret_next        = S_EMIT;
                    state_next      = S_ROUND;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.word_idx = cnt_reg[2:0];
                    if (cnt_reg[2:0] == LAST_WORD_IDX)
                    begin
                        cmd.clear  = 1'b1;
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_load_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rounds |=> (state_reg == S_ROUND) && (cnt_reg == '0))
        else $error("round loop did not start at round zero");

    a_last_round_folds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) && (cnt_reg == LAST_ROUND) |=> state_reg == S_FOLD)
        else $error("fold did not follow the last round");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> cnt_reg <= LAST_ROUND)
        else $error("round counter out of range");

endmodule
`default_nettype wire

>>> hdl/sha1md_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1md_dp
// Datapath: block buffer that doubles as the schedule window, round
// registers, chain value, length counter and the output register.
// ----------------------------------------------------------------------------
module sha1md_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       msg_byte,
    input  wire sha1md_pkg::cmd_t cmd,
    output sha1md_pkg::sts_t      sts,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word
);
    import sha1md_pkg::*;

    logic [31:0]           buf_reg   [BLOCK_WORDS];
    logic [31:0]           rnd_reg   [DIGEST_WORDS];
    logic [31:0]           chain_reg [DIGEST_WORDS];
    logic [FILL_W-1:0]     fill_reg;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg;
    logic                  out_valid_reg;
    logic [31:0]           digest_reg;
    logic [2:0]            index_reg;
    logic                  last_reg;

    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic [7:0]  put_byte;
    logic [31:0] cur_word;
    logic [31:0] put_word;
    logic [31:0] sched_mix;
    logic [31:0] sched_new;
    logic [31:0] f_val;
    logic [31:0] temp;

    assign bit_len  = {byte_cnt_reg, 3'b000};
    // length bytes go out most significant first at positions 56..63
    assign len_byte = 8'(bit_len >> {~fill_reg[2:0], 3'b000});

    always_comb
    begin
        unique case (cmd.byte_sel)
            SEL_MSG:  put_byte = msg_byte;
            SEL_PAD:  put_byte = PAD_BYTE;
            SEL_ZERO: put_byte = 8'h00;
            SEL_LEN:  put_byte = len_byte;
            default:  put_byte = 8'h00;
        endcase
    end

    assign cur_word = buf_reg[fill_reg[5:2]];

    // first byte of a word overwrites it, so stale schedule words drop out
    always_comb
    begin
        unique case (fill_reg[1:0])
            2'd0:    put_word = {put_byte, 24'h000000};
            2'd1:    put_word = cur_word | {8'h00, put_byte, 16'h0000};
            2'd2:    put_word = cur_word | {16'h0000, put_byte, 8'h00};
            2'd3:    put_word = cur_word | {24'h000000, put_byte};
            default: put_word = cur_word;
        endcase
    end

    assign sched_mix = buf_reg[13] ^ buf_reg[8] ^ buf_reg[2] ^ buf_reg[0];
    assign sched_new = {sched_mix[30:0], sched_mix[31]};

    always_comb
    begin
        unique case (cmd.stage)
            2'd0:    f_val = (rnd_reg[1] & rnd_reg[2]) | (~rnd_reg[1] & rnd_reg[3]);
            2'd2:    f_val = (rnd_reg[1] & rnd_reg[2]) | (rnd_reg[1] & rnd_reg[3])
                             | (rnd_reg[2] & rnd_reg[3]);
            default: f_val = rnd_reg[1] ^ rnd_reg[2] ^ rnd_reg[3];
        endcase
    end

    assign temp = {rnd_reg[0][26:0], rnd_reg[0][31:27]} + f_val + rnd_reg[4]
                  + buf_reg[0] + ROUND_K[cmd.stage];

    // block buffer and working registers: no reset, always written before use
    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
                buf_reg[i] <= buf_reg[i + 1];
            buf_reg[BLOCK_WORDS - 1] <= sched_new;
        end
        else if (cmd.put)
        begin
            buf_reg[fill_reg[5:2]] <= put_word;
        end

        if (cmd.load_rounds)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                rnd_reg[i] <= chain_reg[i];
        end
        else if (cmd.round)
        begin
            rnd_reg[4] <= rnd_reg[3];
            rnd_reg[3] <= rnd_reg[2];
            rnd_reg[2] <= {rnd_reg[1][1:0], rnd_reg[1][31:2]};
            rnd_reg[1] <= rnd_reg[0];
            rnd_reg[0] <= temp;
        end

        if (cmd.emit)
        begin
            digest_reg <= chain_reg[cmd.word_idx];
            index_reg  <= cmd.word_idx;
            last_reg   <= (cmd.word_idx == LAST_WORD_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_reg[i] <= H_INIT[i];
            fill_reg      <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                    chain_reg[i] <= H_INIT[i];
                fill_reg     <= '0;
                byte_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.fold)
                begin
                    for (int i = 0; i < DIGEST_WORDS; i++)
                        chain_reg[i] <= chain_reg[i] + rnd_reg[i];
                end
                if (cmd.put)
                    fill_reg <= fill_reg + 1'b1;
                if (cmd.put && cmd.count_len)
                    byte_cnt_reg <= byte_cnt_reg + 1'b1;
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.fill_last  = (fill_reg == FILL_FULL);
    assign sts.fill_is_56 = (fill_reg == FILL_LEN_POS);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign digest_word = digest_reg;
    assign word_index  = index_reg;
    assign last_word   = last_reg;

    a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (fill_reg == '0) && (byte_cnt_reg == '0))
        else $error("message state not cleared after digest");

endmodule
`default_nettype wire

>>> hdl/sha1_message_digest.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte stream: at most one byte per item in, five 32-bit
// digest words out after the end-of-message item.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ----------------------------------
//  in       sink       in_valid / in_stall  msg_byte, byte_present,
//                                           end_of_message
//  out      source     out_valid/out_stall  digest_word, word_index, last_word
//
//  A byte item is taken while the sequencer is idle; the item that fills a
//  64-byte block is followed by 80 rounds of the single round unit plus the
//  chain-value fold, during which no item is taken. End of message: the pad
//  byte, zero bytes up to the length field (through a second block when 56 or
//  more bytes were held), an idle step where the length field starts, the
//  length bytes, a compression for each full block, then the five digest
//  words, each sent once the output register is free.
//  After reset the block accepts items at once; no clearing pass is needed.
//  in_stall is high whenever the sequencer is not idle; a stalled last digest
//  word holds in the output register while new input items are taken.
//
module sha1_message_digest (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha1md_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: decides per cycle whether to absorb, pad, round or emit
    sha1md_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .in_stall       (in_stall),
        .sts            (sts),
        .cmd            (cmd)
    );

    // datapath: buffer, schedule window, round unit, chain and output register
    sha1md_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_byte    (msg_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule
`default_nettype wire

>>> tb/sha1_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Watches both channels of the SHA-1 digest engine, computes the digest of
// each accepted message on its own and compares every delivered digest word.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] digest_word,
    input  wire logic [2:0]  word_index,
    input  wire logic        last_word,
    output int               mismatch_count,
    output int               words_pending
);

    localparam logic [31:0] K_STAGE [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam logic [31:0] CHAIN_START [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_out_t;

    logic [31:0] blk_w [16];
    logic [31:0] chain_h [5];
    logic [63:0] msg_bits;
    logic [5:0]  fill;
    digest_out_t digest_expect_q [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic restart_digest();
        for (int i = 0; i < 5; i++)
            chain_h[i] = CHAIN_START[i];
        for (int i = 0; i < 16; i++)
            blk_w[i] = '0;
        msg_bits = '0;
        fill     = '0;
    endtask

    task automatic compress_block();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, x, t_sum;
        for (int t = 0; t < 16; t++)
            sched[t] = blk_w[t];
        for (int t = 16; t < 80; t++)
        begin
            x = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
            sched[t] = {x[30:0], x[31]};
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 20)
                f = (b & c) | (~b & d);
            else if (t >= 40 && t < 60)
                f = (b & c) | (b & d) | (c & d);
            else
                f = b ^ c ^ d;
            k = K_STAGE[t / 20];
            t_sum = {a[26:0], a[31:27]} + f + e + sched[t] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t_sum;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
        chain_h[3] += d; chain_h[4] += e;
    endtask

    // big-endian placement; the first byte of a word clears the rest of it
    task automatic put_byte(input logic [5:0] pos, input logic [7:0] b);
        if (pos[1:0] == 2'd0)
            blk_w[pos[5:2]] = {b, 24'h0};
        else
            blk_w[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
    endtask

    task automatic absorb_item(input logic [7:0] b, input logic present, input logic eom);
        if (present)
        begin
            put_byte(fill, b);
            msg_bits += 64'd8;
            fill++;
            if (fill == 6'd0)
                compress_block();
        end
        if (eom)
        begin
            put_byte(fill, PAD_MARK);
            for (int w = int'(fill >> 2) + 1; w < 16; w++)
                blk_w[w] = '0;
            // late padding: length no longer fits, spill into a second block
            if (fill >= 6'd56)
            begin
                compress_block();
                for (int w = 0; w < 16; w++)
                    blk_w[w] = '0;
            end
            blk_w[14] = msg_bits[63:32];
            blk_w[15] = msg_bits[31:0];
            compress_block();
            for (int i = 0; i < 5; i++)
                digest_expect_q.push_back('{word: chain_h[i], idx: 3'(i), last: (i == 4)});
            restart_digest();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_out_t want;
        if (!rst_n)
        begin
            restart_digest();
            digest_expect_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_expect_q.size() == 0)
                    report_mismatch($sformatf("digest word %h with none expected", digest_word));
                else
                begin
                    want = digest_expect_q.pop_front();
                    if (digest_word !== want.word)
                        report_mismatch($sformatf("digest_word got %h want %h",
                                                  digest_word, want.word));
                    if (word_index !== want.idx)
                        report_mismatch($sformatf("word_index got %0d want %0d",
                                                  word_index, want.idx));
                    if (last_word !== want.last)
                        report_mismatch($sformatf("last_word got %b want %b",
                                                  last_word, want.last));
                end
            end
            if (in_valid && !in_stall)
                absorb_item(msg_byte, byte_present, end_of_message);
        end
        words_pending = digest_expect_q.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the SHA-1 digest engine: directed corner messages,
// then random messages under bursty input and random output stalls.
// ----------------------------------------------------------------------------
module tb_top;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  msg_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int mismatch_count;
    int words_pending;

    // items that carry a byte or close a message; idle items are not counted
    int items_sent = 0;
    int burst_left = 0;
    // set when the random part starts; the receiver answers with one long hold
    bit want_hold  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sha1_message_digest i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .msg_byte       (msg_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    sha1_digest_checker u_digest_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .msg_byte       (msg_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // Offer one item and hold it until accepted. Entered and left just after
    // a falling edge. Between bursts, drop valid for a random gap; some bursts
    // are long so that stretches with no idling occur too.
    task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 16);
            in_valid   = 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        in_valid       = 1'b1;
        msg_byte       = b;
        byte_present   = present;
        end_of_message = eom;
        do
            @(posedge clk);
        while (in_stall);
        if (present || eom)
            items_sent++;
        @(negedge clk);
    endtask

    // One message of n bytes with random content. Sprinkle idle items in
    // between; close either with the last byte or with an empty closing item
    // whose msg_byte must be ignored.
    task automatic send_message(input int n_bytes);
        logic fold_last;
        fold_last = (n_bytes > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, fold_last && (i == n_bytes - 1));
        end
        if (!fold_last)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Receiver: switches between random stall modes (none, light, heavy,
    // alternating). Once the random part starts, hold off in one long stretch
    // while the sender keeps offering items, so the engine backs up.
    initial
    begin
        int mode;
        int mode_left;
        bit hold_done;
        out_stall = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (want_hold && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (500) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = 50;
            end
            mode_left--;
            case (mode)
                0: out_stall = 1'b0;
                1: out_stall = ($urandom_range(0, 3) == 0);
                2: out_stall = ($urandom_range(0, 3) != 0);
                default: out_stall = ~out_stall;
            endcase
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int fixed_len [4];
        int wait_cycles;
        fixed_len      = '{55, 56, 63, 64};
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        msg_byte       = 8'h00;
        byte_present   = 1'b0;
        end_of_message = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty message; the ignored byte is all ones
        send_item(8'hFF, 1'b0, 1'b1);
        // idle item changes nothing
        send_item(8'hA5, 1'b0, 1'b0);
        // "abc", final byte carried by the closing item
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // zero byte, then an empty closing item with a stray byte
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        // single all-ones byte closing at once
        send_item(8'hFF, 1'b1, 1'b1);
        // pad-like and sign-bit bytes with an idle item in between
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);

        // random part: block-boundary lengths first (padding just fits,
        // late padding, full block), then short random messages
        want_hold = 1'b1;
        foreach (fixed_len[i])
            send_message(fixed_len[i]);
        while (items_sent < 370)
            send_message($urandom_range(0, 40));
        in_valid = 1'b0;

        // drain, then let the engine sit a while to catch stray words
        wait_cycles = 0;
        while (words_pending != 0 && wait_cycles < 50000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);

        if (words_pending != 0)
            $display("error: %0d digest words never arrived", words_pending);
        if (mismatch_count == 0 && words_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/sha1md_pkg.sv
hdl/sha1md_ctrl.sv
hdl/sha1md_dp.sv
hdl/sha1_message_digest.sv
tb/sha1_digest_checker.sv
tb/tb_top.sv
